// ===== sv/s2da_pkg.sv =====
// shared types and constants for the signed to decimal ascii converter
// no dependencies; imported by s2da_bcd_step and signed_to_decimal_ascii_top
package s2da_pkg;

    // binary bits folded into the bcd register per conversion cycle
    localparam int BITS_PER_STEP = 4;
    localparam int BCD_DIGIT_W   = 4;
    localparam int CHAR_W        = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } s2da_state_t;

endpackage

// ===== sv/s2da_bcd_step.sv =====
// shift-and-add-3 unit: moves BITS_PER_STEP binary bits into a packed bcd register
// depends on s2da_pkg
module s2da_bcd_step #(
    parameter int NUM_DIGITS = 20,
    parameter int SHIFT_W    = 64
) (
    input  logic [NUM_DIGITS*s2da_pkg::BCD_DIGIT_W-1:0] bcd_in,
    input  logic [SHIFT_W-1:0]                          bin_in,
    output logic [NUM_DIGITS*s2da_pkg::BCD_DIGIT_W-1:0] bcd_out,
    output logic [SHIFT_W-1:0]                          bin_out
);
    import s2da_pkg::*;

    localparam int BCD_W = NUM_DIGITS * BCD_DIGIT_W;
    localparam int ACC_W = BCD_W + SHIFT_W;

    logic [ACC_W-1:0] acc;

    always_comb
    begin
        acc = {bcd_in, bin_in};
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            // digits are corrected independently, then the whole word shifts
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (acc[SHIFT_W + d*BCD_DIGIT_W +: BCD_DIGIT_W] >= 4'd5)
                begin
                    acc[SHIFT_W + d*BCD_DIGIT_W +: BCD_DIGIT_W] =
                        acc[SHIFT_W + d*BCD_DIGIT_W +: BCD_DIGIT_W] + 4'd3;
                end
            end
            acc = {acc[ACC_W-2:0], 1'b0};
        end
        bcd_out = acc[ACC_W-1:SHIFT_W];
        bin_out = acc[SHIFT_W-1:0];
    end

endmodule

// ===== sv/signed_to_decimal_ascii_top.sv =====
// top level of the signed to decimal ascii converter: sequencer, registers, output stage
// depends on s2da_pkg and s2da_bcd_step
//
// Takes one VALUE_WIDTH-bit two's-complement value and emits its decimal text one ASCII
// character per item, most significant first, with a leading '-' for negative values, no
// leading zeros, and last_char set on the final character. The most negative value is
// converted exactly. One value occupies the block for an accept step, ceil(VALUE_WIDTH/4)
// conversion steps in the shared shift-and-add-3 unit (4 bits per cycle), a sign step
// when negative, and one step per bcd digit position (floor(VALUE_WIDTH*0.30103)+1),
// leading zeros being skipped one per cycle; the sign and each emitted digit wait while
// the output side is stalled. value_stall is high for the whole conversion; the last
// character sits in the output register while the next value is already accepted.
module signed_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            value_valid,
    output logic                            value_stall,
    input  logic signed [VALUE_WIDTH-1:0]   value,
    output logic                            char_valid,
    input  logic                            char_stall,
    output logic [s2da_pkg::CHAR_W-1:0]     ascii_char,
    output logic                            last_char
);
    import s2da_pkg::*;

    localparam int STEPS      = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W      = STEPS * BITS_PER_STEP;
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * BCD_DIGIT_W;
    localparam int STEP_W     = $clog2(STEPS);
    localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

    s2da_state_t              state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic                     started_reg, started_next;
    logic                     neg_reg, neg_next;
    logic [PAD_W-1:0]         bin_reg, bin_next;
    logic [BCD_W-1:0]         bcd_reg, bcd_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]        out_char_reg, out_char_next;
    logic                     out_last_reg, out_last_next;

    logic                     accept;
    logic                     load_ok;
    logic                     neg_in;
    logic [VALUE_WIDTH-1:0]   mag_in;
    logic [BCD_DIGIT_W-1:0]   top_digit;
    logic                     digit_last;
    logic                     skip_zero;
    logic [BCD_W-1:0]         bcd_step;
    logic [PAD_W-1:0]         bin_step;

    assign accept      = value_valid && !value_stall;
    assign value_stall = (state_reg != ST_IDLE);
    assign load_ok     = !out_valid_reg || !char_stall;
    assign neg_in      = value[VALUE_WIDTH-1];
    assign mag_in      = neg_in ? (~value + 1'b1) : value;
    assign top_digit   = bcd_reg[BCD_W-1 -: BCD_DIGIT_W];
    assign digit_last  = (dcnt_reg == DCNT_W'(1));
    assign skip_zero   = !started_reg && (top_digit == '0) && !digit_last;

    assign char_valid  = out_valid_reg;
    assign ascii_char  = out_char_reg;
    assign last_char   = out_last_reg;

    s2da_bcd_step #(
        .NUM_DIGITS (NUM_DIGITS),
        .SHIFT_W    (PAD_W)
    ) u_bcd_step (
        .bcd_in  (bcd_reg),
        .bin_in  (bin_reg),
        .bcd_out (bcd_step),
        .bin_out (bin_step)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (step_reg == '0)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (load_ok)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (!skip_zero && load_ok && digit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        step_next      = step_reg;
        dcnt_next      = dcnt_reg;
        started_next   = started_reg;
        neg_next       = neg_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && char_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next    = STEP_W'(STEPS - 1);
                    dcnt_next    = DCNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    neg_next     = neg_in;
                    bin_next     = PAD_W'(mag_in);
                    bcd_next     = '0;
                end
            end
            ST_CONVERT:
            begin
                bin_next  = bin_step;
                bcd_next  = bcd_step;
                step_next = step_reg - 1'b1;
            end
            ST_SIGN:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                end
            end
            ST_DIGITS:
            begin
                if (skip_zero)
                begin
                    bcd_next  = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + CHAR_W'(top_digit);
                    out_last_next  = digit_last;
                    started_next   = 1'b1;
                    bcd_next  = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            dcnt_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dcnt_reg      <= dcnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    a_accept_starts_convert: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CONVERT))
        else $error("accepted value did not start conversion");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (ascii_char == CHAR_MINUS
                        || (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_NINE)))
        else $error("output character out of range");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && ascii_char == CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last character");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS) |-> (dcnt_reg != '0))
        else $error("digit scan ran past the last digit");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS && !skip_zero && load_ok && digit_last)
            |=> (state_reg == ST_IDLE && char_valid && last_char))
        else $error("last digit not loaded with its flag");

endmodule
